// ===== rtl/prm_pkg.sv =====
// prm_pkg: shared types and constants for the path rtt monitor
// used by prm_ctrl, prm_dp and path_rtt_monitor; no dependencies
`timescale 1ns / 1ps

package prm_pkg;

  localparam int unsigned DW = 32;
  localparam int unsigned IW = 16;
  localparam int unsigned IN_TDATA_W = 64;
  localparam int unsigned OUT_TDATA_W = 192;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_BEAT   = 1'b1;

  localparam logic [DW-1:0] RTT_MIN_SAMPLE = 32'd5;
  localparam logic [DW-1:0] RTT_FLOOR      = 32'd10;
  localparam logic [DW-1:0] VAR_RESET      = 32'd5;
  localparam logic [IW-1:0] INTERVAL_RESET = 16'd1000;

  typedef struct packed {
    logic load_in;
    logic clamp;
    logic upd1;
    logic upd2;
    logic beat;
    logic div_step;
    logic load_out;
  } prm_cmd_t;

  typedef struct packed {
    logic need_div;
  } prm_stat_t;

endpackage

// ===== rtl/prm_ctrl.sv =====
// prm_ctrl: sequencer for the path rtt monitor
// drives prm_dp through prm_pkg::prm_cmd_t, owns the input and output handshakes
`timescale 1ns / 1ps

module prm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_kind,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  prm_pkg::prm_stat_t stat,
  output prm_pkg::prm_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLAMP = 3'd1;
  localparam logic [2:0] S_UPD1  = 3'd2;
  localparam logic [2:0] S_UPD2  = 3'd3;
  localparam logic [2:0] S_BEAT  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                   state_r, state_nxt;
  logic [prm_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = (in_kind == prm_pkg::CMD_BEAT) ? S_BEAT : S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_UPD1;
      end
      S_UPD1: begin
        cmd.upd1  = 1'b1;
        state_nxt = S_UPD2;
      end
      S_UPD2: begin
        cmd.upd2    = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = stat.need_div ? S_DIV : S_DONE;
      end
      S_BEAT: begin
        cmd.beat  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == '1) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/prm_dp.sv =====
// prm_dp: rtt estimator state, serial average divider and result register
// steered by prm_ctrl; types and constants from prm_pkg
`timescale 1ns / 1ps

module prm_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  prm_pkg::prm_cmd_t                  cmd,
  output prm_pkg::prm_stat_t                 stat,
  input  logic                               cfg_we,
  input  logic [prm_pkg::IW-1:0]             cfg_data,
  input  logic                               in_kind,
  input  logic [prm_pkg::IN_TDATA_W-1:0]     in_data,
  output logic [1:0]                         out_flags,
  output logic [prm_pkg::OUT_TDATA_W-1:0]    out_data
);

  localparam int unsigned DW = prm_pkg::DW;

  logic [prm_pkg::IW-1:0] interval_r;
  logic          kind_r;
  logic [DW-1:0] sample_r, now_r, kept_r, diff_r;
  logic [DW-1:0] cur_r, var_r, min_r, count_r, total_r, largest_r, last_r, pings_r;
  logic [DW-1:0] rem_r, quo_r;
  logic          ping_flag_r, valid_flag_r;
  logic [1:0]    out_flags_r;
  logic [prm_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [DW-1:0] var_sum, var_new, cur_new, count_inc, total_inc, elapsed;
  logic [DW:0]   div_shift, div_trial;
  logic [DW-1:0] avg_out, max_out;

  assign var_sum   = {var_r[DW-2:0], 1'b0} + var_r + diff_r;
  assign var_new   = {2'b00, var_sum[DW-1:2]};
  assign cur_new   = (kept_r < prm_pkg::RTT_FLOOR) ? prm_pkg::RTT_FLOOR : kept_r;
  assign count_inc = count_r + 1'b1;
  assign total_inc = total_r + cur_r;
  assign elapsed   = now_r - last_r;
  assign div_shift = {rem_r, quo_r[DW-1]};
  assign div_trial = div_shift - {1'b0, count_r};

  // first sample and wrapped count skip the divider
  assign stat.need_div = (count_r != '0) && (count_inc != '0);

  assign avg_out = (kind_r == prm_pkg::CMD_BEAT) ? '0 : quo_r;
  assign max_out = (kind_r == prm_pkg::CMD_BEAT) ? '0 : largest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= prm_pkg::INTERVAL_RESET;
      cur_r      <= '0;
      var_r      <= prm_pkg::VAR_RESET;
      min_r      <= '0;
      count_r    <= '0;
      total_r    <= '0;
      largest_r  <= '0;
      last_r     <= '0;
      pings_r    <= '0;
    end else begin
      if (cfg_we) begin
        interval_r <= cfg_data;
      end
      if (cmd.upd1) begin
        if (min_r == '0 || kept_r < min_r) begin
          min_r <= kept_r;
        end
        cur_r   <= cur_new;
        last_r  <= now_r;
        pings_r <= '0;
      end
      if (cmd.upd2) begin
        var_r <= (var_new < prm_pkg::RTT_FLOOR) ? prm_pkg::RTT_FLOOR : var_new;
        if (count_r == '0) begin
          count_r   <= {{(DW-1){1'b0}}, 1'b1};
          total_r   <= cur_r;
          largest_r <= cur_r;
        end else begin
          count_r <= count_inc;
          total_r <= total_inc;
          if (cur_r > largest_r) begin
            largest_r <= cur_r;
          end
        end
      end
      if (cmd.beat) begin
        if (last_r != '0 && elapsed > {{(DW-prm_pkg::IW){1'b0}}, interval_r}) begin
          last_r  <= now_r;
          pings_r <= pings_r + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r   <= in_kind;
      sample_r <= in_data[DW-1:0];
      now_r    <= in_data[2*DW-1:DW];
    end
    if (cmd.clamp) begin
      kept_r <= (sample_r > prm_pkg::RTT_MIN_SAMPLE) ? sample_r : prm_pkg::RTT_MIN_SAMPLE;
    end
    if (cmd.upd1) begin
      diff_r       <= (cur_r > kept_r) ? (cur_r - kept_r) : (kept_r - cur_r);
      ping_flag_r  <= 1'b0;
      valid_flag_r <= 1'b1;
    end
    if (cmd.upd2) begin
      rem_r <= '0;
      if (count_r == '0) begin
        quo_r <= cur_r;
      end else if (count_inc == '0) begin
        quo_r <= '1;
      end else begin
        quo_r <= total_inc;
      end
    end
    if (cmd.beat) begin
      valid_flag_r <= 1'b0;
      ping_flag_r  <= (last_r != '0) &&
                      (elapsed > {{(DW-prm_pkg::IW){1'b0}}, interval_r});
    end
    // restoring division, one quotient bit per step
    if (cmd.div_step) begin
      if (!div_trial[DW]) begin
        rem_r <= div_trial[DW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= div_shift[DW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      out_flags_r <= {valid_flag_r, ping_flag_r};
      out_data_r  <= {pings_r, min_r, var_r, cur_r, max_out, avg_out};
    end
  end

  assign out_flags = out_flags_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/path_rtt_monitor.sv =====
// path_rtt_monitor: round-trip time tracker for one network path, top level
// flow: an rtt sample is clamped, updated in the UPD1 and UPD2 steps and, but for the first
// sample or a wrapped count, sent through the serial average divider; a heartbeat has a beat step
// throughput: one item at a time, next item taken the cycle after the result
// enters the output register; cfg writes taken every cycle
// reset: synchronous active-low rst_n restores all tracking state and the interval 1000
`timescale 1ns / 1ps

module path_rtt_monitor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [prm_pkg::IN_TDATA_W-1:0]  in_tdata,   // rtt_sample, now_ms
  input  logic                            in_tuser,   // command
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [prm_pkg::OUT_TDATA_W-1:0] out_tdata,  // report_average, report_max,
                                                      // smoothed_rtt, rtt_variation,
                                                      // min_rtt, ping_count
  output logic [1:0]                      out_tuser,  // ping_request, report_valid
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [prm_pkg::IW-1:0]          cfg_data    // heartbeat interval in ms
);

  prm_pkg::prm_cmd_t  cmd;
  prm_pkg::prm_stat_t stat;

  assign cfg_ready = 1'b1;

  prm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  prm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_kind   (in_tuser),
    .in_data   (in_tdata),
    .out_flags (out_tuser),
    .out_data  (out_tdata)
  );

  // a result never both requests a ping and reports
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("ping request and report in one result");

  // a report carries floored rtt and variation
  a_report_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |->
      (out_tdata[95:64] >= prm_pkg::RTT_FLOOR) && (out_tdata[127:96] >= prm_pkg::RTT_FLOOR))
    else $error("report below floor");

  // minimum never exceeds the smoothed rtt
  a_min_le_cur: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[159:128] <= out_tdata[95:64]))
    else $error("min rtt above smoothed rtt");

  // no new item while a result is being formed
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while busy");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for path_rtt_monitor
// streams rtt samples and heartbeat ticks, predicts every result in the bench itself
// depends on prm_pkg and path_rtt_monitor
`timescale 1ns / 1ps

module tb_top;
  import prm_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned HOLD_AT     = 250;
  localparam int unsigned HOLD_LEN    = 400;
  localparam int unsigned MAX_SHOWN   = 10;

  // result field slots, lowest first
  localparam int R_PING  = 0;
  localparam int R_VALID = 1;
  localparam int R_AVG   = 2;
  localparam int R_MAX   = 3;
  localparam int R_SRTT  = 4;
  localparam int R_VAR   = 5;
  localparam int R_MIN   = 6;
  localparam int R_PINGS = 7;

  typedef struct packed {
    logic          cmd;
    logic [DW-1:0] sample;
    logic [DW-1:0] now_ms;
  } probe_item_t;

  typedef logic [7:0][DW-1:0] rtt_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [IW-1:0]          cfg_data   = '0;

  // bench copy of the tracking state
  logic [DW-1:0] est_srtt, est_var, est_min, est_count;
  logic [DW-1:0] est_total, est_peak, est_last, est_pings;
  logic [IW-1:0] est_interval;

  probe_item_t   cmd_backlog[$];
  rtt_result_t   rtt_reports_due[$];
  probe_item_t   cur_cmd;
  rtt_result_t   got, want;
  logic [DW-1:0] clock_ms;

  int unsigned quiet_left [2];
  int unsigned send_gap, take_wait, hold_left, stall_cycles;
  int unsigned n_bad, n_results;
  bit          hold_used;

  string fld_name [8] = '{"ping_request", "report_valid", "report_average", "report_max",
                          "smoothed_rtt", "rtt_variation", "min_rtt", "ping_count"};

  path_rtt_monitor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic rtt_result_t track_rtt(input probe_item_t it);
    rtt_result_t   r;
    logic [DW-1:0] kept, dev;
    r = '0;
    if (it.cmd == CMD_SAMPLE) begin
      kept = (it.sample > RTT_MIN_SAMPLE) ? it.sample : RTT_MIN_SAMPLE;
      if (est_min == '0 || kept < est_min) est_min = kept;
      dev = (est_srtt > kept) ? est_srtt - kept : kept - est_srtt;
      est_var = (est_var * 32'd3 + dev) / 32'd4;
      if (est_var < RTT_FLOOR) est_var = RTT_FLOOR;
      est_srtt  = (kept < RTT_FLOOR) ? RTT_FLOOR : kept;
      est_last  = it.now_ms;
      est_pings = '0;
      if (est_count == '0) begin
        est_total = est_srtt;
        est_peak  = est_srtt;
        est_count = 32'd1;
        r[R_AVG]  = est_srtt;
      end else begin
        est_count = est_count + 32'd1;
        est_total = est_total + est_srtt;
        if (est_srtt > est_peak) est_peak = est_srtt;
        // a count that wraps to zero skips the divider and gives an all-ones average
        r[R_AVG] = (est_count != '0) ? est_total / est_count : '1;
      end
      r[R_MAX]   = est_peak;
      r[R_VALID] = 32'd1;
    end else begin
      // last update at time zero means timing has not started
      if (est_last != '0 && (it.now_ms - est_last) > {16'b0, est_interval}) begin
        est_last  = it.now_ms;
        est_pings = est_pings + 32'd1;
        r[R_PING] = 32'd1;
      end
    end
    r[R_SRTT]  = est_srtt;
    r[R_VAR]   = est_var;
    r[R_MIN]   = est_min;
    r[R_PINGS] = est_pings;
    return r;
  endfunction

  // per-item wait, with occasional stretches of back-to-back items
  function automatic int unsigned next_gap(input int side);
    if (quiet_left[side] > 0) begin
      quiet_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) quiet_left[side] = $urandom_range(10, 40);
    return $urandom_range(0, 16);
  endfunction

  task automatic flag_mismatch(input string what, input logic [DW-1:0] exp_v,
                               input logic [DW-1:0] act_v);
    n_bad++;
    if (n_bad <= MAX_SHOWN)
      $display("mismatch at result %0d, %s: expected %h, got %h", n_results, what, exp_v,
               act_v);
  endtask

  task automatic add_cmd(input logic cmd, input logic [DW-1:0] sample,
                         input logic [DW-1:0] now_ms);
    probe_item_t it;
    it.cmd    = cmd;
    it.sample = sample;
    it.now_ms = now_ms;
    cmd_backlog = {cmd_backlog, it};
  endtask

  // wait until every queued item went in and every result came back
  task automatic drain();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_tvalid || rtt_reports_due.size() != 0);
  endtask

  task automatic write_interval(input logic [IW-1:0] v);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    est_interval = v;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic gen_traffic(input int n);
    logic [DW-1:0] iv, sample, now_ms;
    int unsigned   pick;
    logic          cmd;
    repeat (n) begin
      iv   = {16'b0, est_interval};
      pick = $urandom_range(0, 99);
      if (pick < 40)      clock_ms = clock_ms + $urandom_range(0, iv);
      else if (pick < 80) clock_ms = clock_ms + iv - 32'd1 + $urandom_range(0, 2);
      else if (pick < 95) clock_ms = clock_ms + $urandom_range(0, 1 << 20);
      else                clock_ms = $urandom();
      now_ms = clock_ms;
      cmd    = ($urandom_range(0, 99) < 35) ? CMD_SAMPLE : CMD_BEAT;
      pick   = $urandom_range(0, 99);
      if (pick < 60)      sample = $urandom_range(0, 3000);
      else if (pick < 75) sample = $urandom_range(0, 12);
      else                sample = $urandom();
      // a rare sample at time zero stops the heartbeat timing
      if (cmd == CMD_SAMPLE && $urandom_range(0, 99) == 0) now_ms = '0;
      add_cmd(cmd, sample, now_ms);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) rtt_reports_due = {rtt_reports_due, track_rtt(cur_cmd)};
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          cur_cmd = cmd_backlog[0];
          cmd_backlog.delete(0);
          in_tdata  <= {cur_cmd.now_ms, cur_cmd.sample};
          in_tuser  <= cur_cmd.cmd;
          in_tvalid <= 1'b1;
          send_gap = next_gap(0);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      take_wait = 0;
      hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) take_wait = next_gap(1);
      if (!hold_used && n_results >= HOLD_AT) begin
        hold_used = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (take_wait > 0) begin
        take_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results <= n_results + 1;
      got = {out_tdata, 31'b0, out_tuser[1], 31'b0, out_tuser[0]};
      if (rtt_reports_due.size() == 0) begin
        flag_mismatch("result with nothing expected", '0, got[R_SRTT]);
      end else begin
        want = rtt_reports_due[0];
        rtt_reports_due.delete(0);
        for (int i = 0; i < 8; i++)
          if (got[i] !== want[i]) flag_mismatch(fld_name[i], want[i], got[i]);
      end
    end
  end

  // watchdog on cycles with no item moving anywhere
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    est_srtt     = '0;
    est_var      = VAR_RESET;
    est_min      = '0;
    est_count    = '0;
    est_total    = '0;
    est_peak     = '0;
    est_last     = '0;
    est_pings    = '0;
    est_interval = INTERVAL_RESET;
    clock_ms     = $urandom_range(1, 10000);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // heartbeat before any sample, noise in the sample field
    add_cmd(CMD_BEAT,   32'hFFFF_FFFF, 32'd500);
    // sample below the minimum at time zero: timing stays off
    add_cmd(CMD_SAMPLE, 32'd0,         32'd0);
    add_cmd(CMD_BEAT,   32'd0,         32'd5000);
    add_cmd(CMD_SAMPLE, 32'd4,         32'd100);
    // elapsed equal to the interval, then one past it
    add_cmd(CMD_BEAT,   32'd0,         32'd1100);
    add_cmd(CMD_BEAT,   32'd0,         32'd1101);
    add_cmd(CMD_BEAT,   32'd0,         32'd2102);
    add_cmd(CMD_SAMPLE, 32'd5,         32'd2200);
    add_cmd(CMD_SAMPLE, 32'd6,         32'd2300);
    add_cmd(CMD_SAMPLE, 32'd9,         32'd2400);
    add_cmd(CMD_SAMPLE, 32'd10,        32'd2500);
    add_cmd(CMD_SAMPLE, 32'd11,        32'd2600);
    // large swings: running total and the variation sum wrap
    add_cmd(CMD_SAMPLE, 32'hFFFF_FFFF, 32'd2700);
    add_cmd(CMD_SAMPLE, 32'h8000_0000, 32'd2800);
    add_cmd(CMD_SAMPLE, 32'd5,         32'd2900);
    add_cmd(CMD_SAMPLE, 32'h8000_0000, 32'd3000);
    add_cmd(CMD_SAMPLE, 32'hFFFF_FFFF, 32'd3100);
    // elapsed time across the 32-bit wrap of the clock
    add_cmd(CMD_SAMPLE, 32'd300,       32'hFFFF_FFF0);
    add_cmd(CMD_BEAT,   32'd0,         32'd400);
    add_cmd(CMD_BEAT,   32'd0,         32'hFFFF_FFFF);
    add_cmd(CMD_SAMPLE, 32'd20,        32'hFFFF_FFFF);
    add_cmd(CMD_BEAT,   32'd0,         32'd999);
    // update at time zero stops timing again
    add_cmd(CMD_SAMPLE, 32'd7,         32'd0);
    add_cmd(CMD_BEAT,   32'd0,         32'd3000000);

    gen_traffic(140);
    write_interval(16'd1);
    gen_traffic(70);
    drain();
    gen_traffic(70);
    write_interval(16'hFFFF);
    gen_traffic(140);
    write_interval(IW'($urandom_range(2, 65534)));
    gen_traffic(140);
    write_interval(16'd1000);
    gen_traffic(140);
    write_interval(IW'($urandom_range(2, 200)));
    gen_traffic(140);

    drain();
    repeat (40) @(posedge clk);
    if (n_bad == 0 && rtt_reports_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
